FILE: hw/rtl/heavy_flow_vote_table_core_defines.svh
// assertion macros shared by the checker file
`ifndef HEAVY_FLOW_VOTE_TABLE_CORE_DEFINES_SVH
`define HEAVY_FLOW_VOTE_TABLE_CORE_DEFINES_SVH

// overlapping implication, clocked and reset-gated
`define HFVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("hfvt assertion failed");

// next-cycle implication, clocked and reset-gated
`define HFVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("hfvt assertion failed");

`endif

FILE: hw/rtl/hfvt_pkg.sv
// shared types and constants of the heavy flow vote table
package hfvt_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int VOTE_BITS_DEF   = 32;

	localparam int FUNC_W   = 1;
	localparam int IDX_W    = 10;
	localparam int KEY_HI_W = 40;
	localparam int KEY_LO_W = 64;
	localparam int CNT_W    = 32;
	localparam int LAMBDA_W = 8;

	localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 8'd8;

	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic clr_we;
		logic load;
		logic rd;
		logic ex;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
	} ctrl_sts_t;

endpackage

FILE: hw/rtl/hfvt_ctrl.sv
// sequencer: clearing pass, item accept, bucket read and execute
module hfvt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hfvt_pkg::ctrl_sts_t  sts,
	output hfvt_pkg::ctrl_cmd_t  cmd,
	output logic                 busy
);
	import hfvt_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q == ST_CLEAR) || (state_q == ST_READ);
	assign accept = start && !busy;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.clr_we = (state_q == ST_CLEAR);
		cmd.rd     = (state_q == ST_READ);
		cmd.ex     = (state_q == ST_EXEC);
		state_d    = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// next transaction may enter while this one writes back
				state_d = accept ? ST_READ : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/hfvt_datapath.sv
// bucket memory, vote update logic and result registers
module hfvt_datapath #(
	parameter int NUM_BUCKETS = hfvt_pkg::NUM_BUCKETS_DEF,
	parameter int VOTE_BITS   = hfvt_pkg::VOTE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hfvt_pkg::ctrl_cmd_t             cmd,
	output hfvt_pkg::ctrl_sts_t             sts,
	input  logic [hfvt_pkg::FUNC_W-1:0]     func,
	input  logic [hfvt_pkg::IDX_W-1:0]      bucket_index,
	input  logic [hfvt_pkg::KEY_HI_W-1:0]   key_hi,
	input  logic [hfvt_pkg::KEY_LO_W-1:0]   key_lo,
	input  logic                            cfg_we,
	input  logic [hfvt_pkg::LAMBDA_W-1:0]   cfg_data,
	output logic                            done,
	output logic                            light_valid,
	output logic [hfvt_pkg::KEY_HI_W-1:0]   light_key_hi,
	output logic [hfvt_pkg::KEY_LO_W-1:0]   light_key_lo,
	output logic [hfvt_pkg::CNT_W-1:0]      fwd_count,
	output logic [hfvt_pkg::CNT_W-1:0]      query_count,
	output logic                            replaced_flag
);
	import hfvt_pkg::*;

	localparam int AW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int EW   = KEY_HI_W + KEY_LO_W + 2 * VOTE_BITS + 1;
	localparam int CW   = (VOTE_BITS > CNT_W) ? VOTE_BITS : CNT_W;
	localparam int PW   = VOTE_BITS + LAMBDA_W;
	localparam int KLO0 = 0;
	localparam int KHI0 = KEY_LO_W;
	localparam int POS0 = KEY_LO_W + KEY_HI_W;
	localparam int NEG0 = POS0 + VOTE_BITS;
	localparam int REP0 = NEG0 + VOTE_BITS;
	localparam longint IDX_MAX = (longint'(1) << IDX_W) - 1;

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [VOTE_BITS-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		if (w > CW'({CNT_W{1'b1}})) begin
			return '1;
		end
		return w[CNT_W-1:0];
	endfunction

	logic [EW-1:0]         mem_q [NUM_BUCKETS];
	logic [EW-1:0]         rd_q;
	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         addr_q;
	logic [FUNC_W-1:0]     func_q;
	logic [KEY_HI_W-1:0]   khi_q;
	logic [KEY_LO_W-1:0]   klo_q;
	logic [LAMBDA_W-1:0]   lambda_q;
	logic [IDX_W-1:0]      red;

	logic [KEY_HI_W-1:0]   b_khi;
	logic [KEY_LO_W-1:0]   b_klo;
	logic [VOTE_BITS-1:0]  pos;
	logic [VOTE_BITS-1:0]  neg;
	logic [VOTE_BITS-1:0]  pos_inc;
	logic [VOTE_BITS-1:0]  neg_inc;
	logic [PW-1:0]         prod;
	logic                  match;
	logic                  keep;
	logic                  wr_en;
	logic [EW-1:0]         wr_data;
	logic                  lv_d;
	logic [KEY_HI_W-1:0]   lkh_d;
	logic [KEY_LO_W-1:0]   lkl_d;
	logic [CNT_W-1:0]      lc_d;
	logic [CNT_W-1:0]      hc_d;
	logic                  rf_d;

	// bucket index folded into range by conditional subtraction of shifted sizes
	always_comb begin
		red = bucket_index;
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if ((longint'(NUM_BUCKETS) << k) <= IDX_MAX) begin
				if (longint'(red) >= (longint'(NUM_BUCKETS) << k)) begin
					red = red - IDX_W'(longint'(NUM_BUCKETS) << k);
				end
			end
		end
	end

	assign sts.clr_last = (clr_q == AW'(NUM_BUCKETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			lambda_q <= LAMBDA_RESET;
			done     <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				lambda_q <= cfg_data;
			end
			done <= cmd.ex;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			addr_q <= AW'(red);
			khi_q  <= key_hi;
			klo_q  <= key_lo;
		end
		if (cmd.ex) begin
			light_valid   <= lv_d;
			light_key_hi  <= lkh_d;
			light_key_lo  <= lkl_d;
			fwd_count     <= lc_d;
			query_count   <= hc_d;
			replaced_flag <= rf_d;
		end
	end

	// single write port: clearing pass or execute write-back
	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			mem_q[addr_q] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[addr_q];
		end
	end

	always_comb begin
		b_khi   = rd_q[KHI0 +: KEY_HI_W];
		b_klo   = rd_q[KLO0 +: KEY_LO_W];
		pos     = rd_q[POS0 +: VOTE_BITS];
		neg     = rd_q[NEG0 +: VOTE_BITS];
		match   = (b_khi == khi_q) && (b_klo == klo_q);
		pos_inc = (pos == '1) ? pos : pos + VOTE_BITS'(1);
		neg_inc = (neg == '1) ? neg : neg + VOTE_BITS'(1);
		// floor(neg/pos) < lambda  <=>  neg < lambda * pos, for pos > 0
		prod    = PW'(lambda_q) * PW'(pos);
		keep    = PW'(neg_inc) < prod;

		wr_en   = 1'b0;
		wr_data = rd_q;
		lv_d    = 1'b0;
		lkh_d   = '0;
		lkl_d   = '0;
		lc_d    = '0;
		hc_d    = '0;
		rf_d    = 1'b0;

		if (func_q == FUNC_QUERY) begin
			hc_d = match ? clamp_cnt(pos) : '0;
			rf_d = rd_q[REP0];
		end else if (pos == '0) begin
			wr_en                         = cmd.ex;
			wr_data[KHI0 +: KEY_HI_W]     = khi_q;
			wr_data[KLO0 +: KEY_LO_W]     = klo_q;
			wr_data[POS0 +: VOTE_BITS]    = VOTE_BITS'(1);
		end else if (match) begin
			wr_en                         = cmd.ex;
			wr_data[POS0 +: VOTE_BITS]    = pos_inc;
		end else if (keep) begin
			wr_en                         = cmd.ex;
			wr_data[NEG0 +: VOTE_BITS]    = neg_inc;
			lv_d  = 1'b1;
			lkh_d = khi_q;
			lkl_d = klo_q;
			lc_d  = CNT_W'(1);
		end else begin
			// eviction: resident key goes to the light part
			wr_en                         = cmd.ex;
			wr_data[KHI0 +: KEY_HI_W]     = khi_q;
			wr_data[KLO0 +: KEY_LO_W]     = klo_q;
			wr_data[POS0 +: VOTE_BITS]    = VOTE_BITS'(1);
			wr_data[NEG0 +: VOTE_BITS]    = '0;
			wr_data[REP0]                 = 1'b1;
			lv_d  = 1'b1;
			lkh_d = b_khi;
			lkl_d = b_klo;
			lc_d  = clamp_cnt(pos);
		end
	end

endmodule

FILE: hw/rtl/heavy_flow_vote_table_core.sv
// top level of the heavy flow vote table
// Usage:
//   Command channel: an item (func, bucket_index, key_hi, key_lo) is taken at a
//   rising edge with start high and busy low. func 0 is a packet update, 1 a query.
//   Result channel: done is high for exactly one cycle with the result fields;
//   the receiver cannot stall it, so the block never waits on the output.
//   Sequence: after the accepting edge the item passes the bucket read state and
//   then the execute state, at whose end done and the result fields are registered.
//   Overlap: no item is taken in the bucket read state; the next item is accepted
//   in the execute (write-back) cycle.
//   Configuration: cfg_data writes lambda_threshold when cfg_valid is high;
//   cfg_ready is always high. Write only while no transaction is in flight.
//   Reset: arst_n clears control and sets lambda_threshold to 8, then a clearing
//   pass zeroes the NUM_BUCKETS buckets (1024 by default) one bucket a cycle
//   with busy held high.
module heavy_flow_vote_table_core #(
	parameter int NUM_BUCKETS = hfvt_pkg::NUM_BUCKETS_DEF,
	parameter int VOTE_BITS   = hfvt_pkg::VOTE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hfvt_pkg::FUNC_W-1:0]     func,
	input  logic [hfvt_pkg::IDX_W-1:0]      bucket_index,
	input  logic [hfvt_pkg::KEY_HI_W-1:0]   key_hi,
	input  logic [hfvt_pkg::KEY_LO_W-1:0]   key_lo,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hfvt_pkg::LAMBDA_W-1:0]   cfg_data,
	output logic                            done,
	output logic                            light_valid,
	output logic [hfvt_pkg::KEY_HI_W-1:0]   light_key_hi,
	output logic [hfvt_pkg::KEY_LO_W-1:0]   light_key_lo,
	output logic [hfvt_pkg::CNT_W-1:0]      fwd_count,
	output logic [hfvt_pkg::CNT_W-1:0]      query_count,
	output logic                            replaced_flag
);
	import hfvt_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	hfvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	hfvt_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.VOTE_BITS   (VOTE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.bucket_index  (bucket_index),
		.key_hi        (key_hi),
		.key_lo        (key_lo),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.light_valid   (light_valid),
		.light_key_hi  (light_key_hi),
		.light_key_lo  (light_key_lo),
		.fwd_count     (fwd_count),
		.query_count   (query_count),
		.replaced_flag (replaced_flag)
	);

endmodule

FILE: hw/rtl/hfvt_checker.sv
// port-level checker of the heavy flow vote table and its bind
`include "heavy_flow_vote_table_core_defines.svh"

module hfvt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every accepted transaction yields its result
	`HFVT_ASSERT_IMP(a_result_follows, clk, arst_n, start && !busy, ##3 done)

	// a result never comes without an accepted transaction behind it
	`HFVT_ASSERT_IMP(a_no_phantom, clk, arst_n, done, $past(start && !busy, 3))

	// no two results come in back-to-back cycles
	`HFVT_ASSERT_NXT(a_spacing, clk, arst_n, done, !done)

	// bucket read cycle follows each accept
	`HFVT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, start && !busy, busy)

endmodule

bind heavy_flow_vote_table_core hfvt_checker u_hfvt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
